@@ rtl/core/kmds_pkg.sv @@
// Shared types and constants for the keypad matrix scan and debounce block.
package kmds_pkg;

  // Geometry defaults and limits
  localparam int unsigned Rows      = 3;
  localparam int unsigned Columns   = 8;
  localparam int unsigned MaxRows   = 8;
  localparam int unsigned RowBits   = 8;
  localparam int unsigned InputRows = 3;

  // Field widths
  localparam int unsigned SampleW = InputRows * RowBits;  // 24
  localparam int unsigned KeyW    = 5;
  localparam int unsigned InDataW = 24;
  localparam int unsigned OutDataW = 16;

  // A row with every key up
  localparam logic [RowBits-1:0] RowAllUp = 8'hFF;

  // Change found on one scan tick
  typedef struct packed {
    logic            hit;
    logic [KeyW-1:0] key_number;
    logic            went_down;
  } change_t;

  // Result beat as packed into tdata (lowest field last in this list)
  typedef struct packed {
    logic [KeyW-1:0] keys_down;
    logic            key_pressed;
    logic [KeyW-1:0] key_number;
  } result_t;

endpackage

@@ rtl/core/matrix_key_debounce_scanner_top.sv @@
// Top level of the keypad matrix scanner with debounce.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata[23:0] column_samples
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata[4:0] key_number,
//                                               [5] key_pressed, [10:6] keys_down
//
// One beat in, one beat out; a beat is taken every cycle when the output is free.
// A beat goes through the input register, then compare/encode into the result register.
// The row state updates as the result is registered, so the next beat sees it.
// Reset leaves all keys up, the previous samples all ones and the count at zero.
// A stalled output holds its beat and backs up the input register only.
module matrix_key_debounce_scanner_top #(
  parameter int unsigned ROWS    = kmds_pkg::Rows,
  parameter int unsigned COLUMNS = kmds_pkg::Columns
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [kmds_pkg::InDataW-1:0]  s_axis_tdata,   // [23:0] column_samples
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [kmds_pkg::OutDataW-1:0] m_axis_tdata    // [4:0] key_number,
                                                        // [5] key_pressed,
                                                        // [10:6] keys_down, rest 0
);

  localparam int unsigned RB = kmds_pkg::RowBits;

  logic                         in_vld_q;
  logic [kmds_pkg::SampleW-1:0] in_data_q;
  logic                         out_vld_q;
  kmds_pkg::result_t            out_data_q, out_data_d;
  logic [RB-1:0]                acc_q [ROWS];
  logic [RB-1:0]                prev_q [ROWS];
  logic [RB-1:0]                acc_d [ROWS];
  logic [RB-1:0]                row_val [ROWS];
  logic [kmds_pkg::KeyW-1:0]    count_q, count_d;
  kmds_pkg::change_t            change;
  logic                         advance;

  // Pipeline flow
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[kmds_pkg::SampleW-1:0];
    end
  end

  kmds_detect #(
    .ROWS    (ROWS),
    .COLUMNS (COLUMNS)
  ) u_detect (
    .samples_i (in_data_q),
    .acc_i     (acc_q),
    .prev_i    (prev_q),
    .row_o     (row_val),
    .acc_d_o   (acc_d),
    .change_o  (change)
  );

  // Pressed count and result
  always_comb begin
    count_d = count_q;
    if (change.hit) begin
      if (change.went_down) begin
        count_d = count_q + kmds_pkg::KeyW'(1);
      end else begin
        count_d = count_q - kmds_pkg::KeyW'(1);
      end
    end
    out_data_d.key_number  = change.key_number;
    out_data_d.key_pressed = change.went_down;
    out_data_d.keys_down   = count_d;
  end

  // Row state and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < ROWS; r++) begin
        acc_q[r]  <= kmds_pkg::RowAllUp;
        prev_q[r] <= kmds_pkg::RowAllUp;
      end
      count_q <= '0;
    end else if (advance) begin
      for (int r = 0; r < ROWS; r++) begin
        acc_q[r]  <= acc_d[r];
        prev_q[r] <= row_val[r];
      end
      count_q <= count_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(kmds_pkg::OutDataW - $bits(kmds_pkg::result_t)){1'b0}}, out_data_q};

endmodule

@@ rtl/core/kmds_detect.sv @@
// Debounce compare and priority encode of the first stable key change.
module kmds_detect #(
  parameter int unsigned ROWS    = kmds_pkg::Rows,
  parameter int unsigned COLUMNS = kmds_pkg::Columns
) (
  input  logic [kmds_pkg::SampleW-1:0] samples_i,
  input  logic [kmds_pkg::RowBits-1:0] acc_i   [ROWS],
  input  logic [kmds_pkg::RowBits-1:0] prev_i  [ROWS],
  output logic [kmds_pkg::RowBits-1:0] row_o   [ROWS],
  output logic [kmds_pkg::RowBits-1:0] acc_d_o [ROWS],
  output kmds_pkg::change_t            change_o
);

  localparam int unsigned RB = kmds_pkg::RowBits;
  localparam int unsigned ExtW = kmds_pkg::MaxRows * RB;
  localparam logic [RB-1:0] UsedMask = RB'((9'd1 << COLUMNS) - 9'd1);

  logic [ExtW-1:0] ext;
  logic [RB-1:0]   cand [ROWS];

  // Rows above the input read as all keys up
  assign ext = {{(ExtW - kmds_pkg::SampleW){1'b1}}, samples_i};

  // Padded row samples and stable differing bits per row
  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      if (r < kmds_pkg::InputRows) begin
        row_o[r] = ext[RB*r +: RB] | ~UsedMask;
      end else begin
        row_o[r] = kmds_pkg::RowAllUp;
      end
      cand[r] = ~(row_o[r] ^ prev_i[r]) & (row_o[r] ^ acc_i[r]) & UsedMask;
    end
  end

  // First row in order, lowest column within it
  always_comb begin
    change_o = '0;
    for (int r = 0; r < ROWS; r++) begin
      acc_d_o[r] = acc_i[r];
    end
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLUMNS; c++) begin
        if (!change_o.hit && cand[r][c]) begin
          change_o.hit        = 1'b1;
          change_o.key_number = kmds_pkg::KeyW'(RB * r + c + 1);
          change_o.went_down  = ~row_o[r][c];
          acc_d_o[r][c]       = row_o[r][c];
        end
      end
    end
  end

endmodule

@@ rtl/core/kmds_checker.sv @@
// Port-level checks for the keypad scanner, bound to the top level.
module kmds_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [kmds_pkg::OutDataW-1:0] m_axis_tdata
);

  logic [kmds_pkg::KeyW-1:0] last_down_q;
  logic                      in_beat;
  logic                      out_beat;
  logic [kmds_pkg::KeyW-1:0] kn;
  logic [kmds_pkg::KeyW-1:0] kd;
  logic                      kp;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;
  assign kn = m_axis_tdata[4:0];
  assign kp = m_axis_tdata[5];
  assign kd = m_axis_tdata[10:6];

  // Count shown by the last delivered beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_down_q <= '0;
    end else if (out_beat) begin
      last_down_q <= kd;
    end
  end

  // An accepted sample beat leads to a result beat on offer; under an output stall it may be an earlier beat
  a_in_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |-> ##2 m_axis_tvalid)
    else $error("sample beat produced no result beat");

  // No change carries no press flag and leaves the count alone
  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && kn == '0) |-> (!kp && kd == last_down_q))
    else $error("tick without change altered flag or count");

  // A press or a release moves the count by exactly one
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_beat && kn != '0) |->
      (kp ? (kd == last_down_q + kmds_pkg::KeyW'(1))
          : (kd == last_down_q - kmds_pkg::KeyW'(1))))
    else $error("key count step wrong");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result beat changed");

  // Padding bits stay zero
  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15:11] == '0))
    else $error("result padding not zero");

endmodule

bind matrix_key_debounce_scanner_top kmds_checker u_kmds_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/matrix_key_debounce_scanner_top_tb.sv @@
// Self-checking testbench for the keypad matrix scanner with debounce.
`timescale 1ns / 1ps

module matrix_key_debounce_scanner_top_tb;

  localparam int unsigned InDataW    = kmds_pkg::InDataW;
  localparam int unsigned OutDataW   = kmds_pkg::OutDataW;
  localparam int unsigned RowBits    = kmds_pkg::RowBits;
  localparam int unsigned MaxRows    = kmds_pkg::MaxRows;
  localparam int unsigned InputRows  = kmds_pkg::InputRows;
  localparam int unsigned KeyW       = kmds_pkg::KeyW;
  localparam logic [RowBits-1:0] RowAllUp = kmds_pkg::RowAllUp;
  localparam int unsigned ScanRows   = kmds_pkg::Rows;
  localparam int unsigned ScanCols   = kmds_pkg::Columns;
  localparam int unsigned ResultW    = $bits(kmds_pkg::result_t);
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned LongHold   = 300;

  // Expected outcome of one scan tick
  typedef struct packed {
    logic [KeyW-1:0] key_number;
    logic            key_pressed;
    logic [KeyW-1:0] keys_down;
  } key_event_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata  = '0;   // [23:0] column_samples
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;         // [4:0] key_number, [5] key_pressed,
                                             // [10:6] keys_down, rest 0

  // Pending sample beats and expected key events
  logic [InDataW-1:0] sample_queue[$];
  key_event_t         expected_events[$];

  // Debounce state as the scanner should hold it
  logic [RowBits-1:0] accepted_rows [MaxRows];
  logic [RowBits-1:0] last_rows     [MaxRows];
  logic [KeyW-1:0]    down_count;

  // Traffic shaping, set per phase
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_stall_pct = 0;
  int unsigned hold_requests     = 0;
  int unsigned hold_served       = 0;
  int unsigned hold_left         = 0;

  logic               in_beat_taken = 1'b0;
  int unsigned        mismatch_count = 0;
  int unsigned        event_index    = 0;
  int unsigned        quiet_cycles   = 0;
  logic [InDataW-1:0] key_pattern    = '1;

  matrix_key_debounce_scanner_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // One scan tick: at most one debounced change, found in row order
  function automatic key_event_t scan_tick(input logic [InDataW-1:0] samples);
    key_event_t         res;
    logic [RowBits-1:0] pad;
    logic [RowBits-1:0] row_now;
    logic               found;
    int unsigned        number;
    res    = '0;
    pad    = '0;
    found  = 1'b0;
    number = 0;
    // columns past the matrix read as released
    for (int c = 0; c < RowBits; c++) pad[c] = (c >= ScanCols);
    for (int r = 0; r < ScanRows && r < MaxRows; r++) begin
      row_now = (r < InputRows) ? (samples[RowBits*r +: RowBits] | pad) : RowAllUp;
      if (!found && row_now != accepted_rows[r]) begin
        for (int c = 0; c < ScanCols && c < RowBits; c++) begin
          if (!found && row_now[c] == last_rows[r][c] && row_now[c] != accepted_rows[r][c]) begin
            found               = 1'b1;
            accepted_rows[r][c] = row_now[c];
            number              = RowBits * r + c + 1;
            if (!row_now[c]) begin
              res.key_pressed = 1'b1;
              down_count      = down_count + 1'b1;
            end else begin
              down_count = down_count - 1'b1;
            end
          end
        end
      end
      last_rows[r] = row_now;
    end
    res.key_number = KeyW'(number);
    res.keys_down  = down_count;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("MISMATCH beat %0d %s: got %0d, expected %0d", event_index, what, got_v, want_v);
    mismatch_count++;
  endtask

  // Sender: offers the next sample beat at the falling edge
  always @(negedge clk_i) begin : drive_samples
    logic [InDataW-1:0] next_word;
    if (rst_ni && (!s_axis_tvalid || in_beat_taken)) begin
      if (sample_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_word = sample_queue.pop_front();
        s_axis_tdata  <= next_word;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk_i) begin
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LongHold;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // Monitor: predict on each accepted sample, check each result beat, watchdog
  always @(posedge clk_i) begin : watch_beats
    kmds_pkg::result_t got;
    key_event_t        want;
    logic              any_beat;
    in_beat_taken = 1'b0;
    any_beat      = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_beat_taken = 1'b1;
        any_beat      = 1'b1;
        expected_events.push_back(scan_tick(s_axis_tdata));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        any_beat = 1'b1;
        got      = kmds_pkg::result_t'(m_axis_tdata[ResultW-1:0]);
        if (expected_events.size() == 0) begin
          report_mismatch("result beat with nothing pending", m_axis_tdata, 0);
        end else begin
          want = expected_events.pop_front();
          if (got.key_number != want.key_number)
            report_mismatch("key_number", got.key_number, want.key_number);
          if (got.key_pressed != want.key_pressed)
            report_mismatch("key_pressed", got.key_pressed, want.key_pressed);
          if (got.keys_down != want.keys_down)
            report_mismatch("keys_down", got.keys_down, want.keys_down);
        end
        if (m_axis_tdata[OutDataW-1:ResultW] != '0)
          report_mismatch("tdata padding", m_axis_tdata[OutDataW-1:ResultW], 0);
        event_index++;
      end
    end
    quiet_cycles = any_beat ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Random sample runs: mostly settled patterns held for a few ticks, with
  // contact bounce ahead of them, some long all-down/all-up holds and noise
  task automatic queue_key_activity(input int unsigned beats);
    int unsigned        pushed;
    int unsigned        pick;
    int unsigned        hold;
    logic [InDataW-1:0] target;
    logic [InDataW-1:0] bounce;
    pushed = 0;
    while (pushed < beats) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        sample_queue.push_back(InDataW'($urandom));
        pushed++;
      end else begin
        if (pick < 14) begin
          target = '0;
          hold   = $urandom_range(26, 30);
        end else if (pick < 18) begin
          target = '1;
          hold   = $urandom_range(26, 30);
        end else if (pick < 24) begin
          target = InDataW'($urandom);
          hold   = $urandom_range(2, 6);
        end else begin
          target = key_pattern;
          repeat ($urandom_range(1, 3)) target[$urandom_range(InDataW-1)] ^= 1'b1;
          hold = $urandom_range(2, 5);
        end
        // bounce: part of the transition, sometimes with a stray bit
        if ($urandom_range(99) < 40) begin
          repeat ($urandom_range(1, 2)) begin
            bounce = key_pattern ^ ((target ^ key_pattern) & InDataW'($urandom));
            if ($urandom_range(1)) bounce[$urandom_range(InDataW-1)] ^= 1'b1;
            sample_queue.push_back(bounce);
            pushed++;
          end
        end
        repeat (hold) sample_queue.push_back(target);
        pushed += hold;
        key_pattern = target;
      end
    end
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned beats, input logic long_stall);
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    if (long_stall) hold_requests++;
    queue_key_activity(beats);
    while (sample_queue.size() != 0 || s_axis_tvalid) @(posedge clk_i);
  endtask

  initial begin
    for (int r = 0; r < MaxRows; r++) begin
      accepted_rows[r] = RowAllUp;
      last_rows[r]     = RowAllUp;
    end
    down_count = '0;

    // Directed: bounce, stable press, skipping a bouncing row, release,
    // top-row key, all keys down and up, alternating columns
    sample_queue.push_back(24'hFFFFFF);
    sample_queue.push_back(24'hFFFFFE);
    sample_queue.push_back(24'hFFFFFF);
    sample_queue.push_back(24'hFFFFFE);
    sample_queue.push_back(24'hFFFFFE);
    sample_queue.push_back(24'hFFFFFE);
    sample_queue.push_back(24'h7FFEFE);
    repeat (5) sample_queue.push_back(24'h7FFEFB);
    repeat (3) sample_queue.push_back(24'h000000);
    repeat (4) sample_queue.push_back(24'hFFFFFF);
    repeat (2) sample_queue.push_back(24'hAAAAAA);
    repeat (2) sample_queue.push_back(24'h555555);

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_phase(0,  0,  187, 1'b1);
    run_phase(68, 0,  210, 1'b0);
    run_phase(0,  68, 210, 1'b0);
    run_phase(28, 28, 210, 1'b0);
    run_phase(0,  0,  210, 1'b1);

    // drain, then keep watching for any stray beat
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/kmds_pkg.sv
rtl/core/kmds_detect.sv
rtl/core/matrix_key_debounce_scanner_top.sv
rtl/core/kmds_checker.sv
tb/matrix_key_debounce_scanner_top_tb.sv
